>>> hw/rtl/counting_semaphore_timed_waits_assert.svh
// Assertion macros shared by the semaphore RTL.
`ifndef COUNTING_SEMAPHORE_TIMED_WAITS_ASSERT_SVH
`define COUNTING_SEMAPHORE_TIMED_WAITS_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CSTW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define CSTW_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CSTW_ASSERT(name, clk, rst_n, prop)
`define CSTW_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/cstw_pkg.sv
// Shared constants and types of the counting semaphore.
package cstw_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Event codes of a result word
  localparam logic [2:0] EV_GRANTED   = 3'd0;
  localparam logic [2:0] EV_BLOCKED   = 3'd1;
  localparam logic [2:0] EV_SIGNALLED = 3'd2;
  localparam logic [2:0] EV_TIMEDOUT  = 3'd3;
  localparam logic [2:0] EV_NONE      = 3'd4;
  localparam logic [2:0] EV_REPORT    = 3'd5;
  localparam logic [2:0] EV_FULL      = 3'd6;

  // Count and register geometry
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned INIT_W  = 15;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;
  localparam logic signed [COUNT_W:0]   COUNT_SAT = 17'sd32767;
  localparam logic REG_INIT_IDX = 1'b0;

  // Per-cell move control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> hw/rtl/cstw_cell.sv
// One waiter slot of the queue chain.
module cstw_cell #(
  parameter int unsigned ID_W = 8,
  parameter int unsigned TO_W = 16
) (
  input  logic                clk_i,
  input  cstw_pkg::cell_ctl_t ctl_i,
  input  logic [ID_W-1:0]     nb_id_i,
  input  logic [TO_W-1:0]     nb_ticks_i,
  input  logic                nb_forever_i,
  input  logic                nb_exp_i,
  input  logic [ID_W-1:0]     ld_id_i,
  input  logic [TO_W-1:0]     ld_ticks_i,
  input  logic                ld_forever_i,
  input  logic                ld_exp_i,
  output logic [ID_W-1:0]     id_o,
  output logic [TO_W-1:0]     ticks_o,
  output logic                forever_o,
  output logic                exp_o
);
  import cstw_pkg::*;

  logic [ID_W-1:0] id_q, id_d;
  logic [TO_W-1:0] ticks_q, ticks_d;
  logic            forever_q, forever_d;
  logic            exp_q, exp_d;

  // Take the broadcast word, else the neighbor word, else hold
  always_comb begin
    id_d      = id_q;
    ticks_d   = ticks_q;
    forever_d = forever_q;
    exp_d     = exp_q;
    if (ctl_i.load) begin
      id_d      = ld_id_i;
      ticks_d   = ld_ticks_i;
      forever_d = ld_forever_i;
      exp_d     = ld_exp_i;
    end else if (ctl_i.shift) begin
      id_d      = nb_id_i;
      ticks_d   = nb_ticks_i;
      forever_d = nb_forever_i;
      exp_d     = nb_exp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    ticks_q   <= ticks_d;
    forever_q <= forever_d;
    exp_q     <= exp_d;
  end

  assign id_o      = id_q;
  assign ticks_o   = ticks_q;
  assign forever_o = forever_q;
  assign exp_o     = exp_q;

endmodule

>>> hw/rtl/counting_semaphore_timed_waits.sv
// Top level: counting semaphore with a chain of timed waiter cells.
//
//  channel   direction  handshake                      payload
//  command   in         start_i taken when !busy_o     opcode_i thread_id_i timeout_ticks_i
//  result    out        result_valid_o, one cycle      event_kind_o released_thread_o
//                                                      count_value_o last_of_run_o
//  config    in/out     APB, write at psel&penable     paddr_i pwdata_i prdata_o
//
// For wait, signal and read the result word follows in the next cycle.
// A tick with queued waiters rotates the chain through its head cell: a first
// pass counts down and marks expiries, then, only when some waiter expired, a
// second pass emits and compacts; busy_o stays high meanwhile,
// and a tick on an empty queue answers in the next cycle like a read.
// Reset empties the queue and clears the count; no clearing pass is needed.
// The receiver cannot stall: every result word is shown for exactly one cycle.
`include "counting_semaphore_timed_waits_assert.svh"

module counting_semaphore_timed_waits #(
  parameter int unsigned MAX_WAITERS    = 16,
  parameter int unsigned THREAD_ID_BITS = 8,
  parameter int unsigned TIMEOUT_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          opcode_i,
  input  logic [THREAD_ID_BITS-1:0]           thread_id_i,
  input  logic [TIMEOUT_BITS-1:0]             timeout_ticks_i,
  // result side
  output logic                                result_valid_o,
  output logic [2:0]                          event_kind_o,
  output logic [THREAD_ID_BITS-1:0]           released_thread_o,
  output logic signed [cstw_pkg::COUNT_W-1:0] count_value_o,
  output logic                                last_of_run_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cstw_pkg::ADDR_W-1:0]         paddr,
  input  logic [cstw_pkg::DATA_W-1:0]         pwdata,
  output logic [cstw_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import cstw_pkg::*;

  localparam int unsigned OCC_W = $clog2(MAX_WAITERS + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(MAX_WAITERS);
  localparam logic [OCC_W-1:0] ONE_STEP = OCC_W'(1);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic [OCC_W-1:0]           step_q, step_d;
  logic [OCC_W-1:0]           nexp_q, nexp_d;
  logic signed [COUNT_W-1:0]  count_q, count_d;
  logic [INIT_W-1:0]          init_q;
  logic                       rv_q, rv_d;
  logic [2:0]                 ev_q, ev_d;
  logic [THREAD_ID_BITS-1:0]  tid_q, tid_d;
  logic                       last_q, last_d;

  // Chain wires; entry MAX_WAITERS is the empty end of the chain
  logic [THREAD_ID_BITS-1:0] c_id      [MAX_WAITERS+1];
  logic [TIMEOUT_BITS-1:0]   c_ticks   [MAX_WAITERS+1];
  logic                      c_forever [MAX_WAITERS+1];
  logic                      c_exp     [MAX_WAITERS+1];

  logic [THREAD_ID_BITS-1:0] ld_id;
  logic [TIMEOUT_BITS-1:0]   ld_ticks;
  logic                      ld_forever, ld_exp;
  logic                      do_shift, do_load;
  logic [OCC_W-1:0]          load_pos;

  logic [TIMEOUT_BITS-1:0]   head_left;
  logic                      head_exp;
  logic [OCC_W-1:0]          nexp_next;
  logic signed [COUNT_W:0]   sum_inc, sum_exp;
  logic signed [COUNT_W-1:0] count_inc, count_exp;
  logic                      accept, cfg_wr, cfg_hit;

  assign c_id[MAX_WAITERS]      = '0;
  assign c_ticks[MAX_WAITERS]   = '0;
  assign c_forever[MAX_WAITERS] = 1'b0;
  assign c_exp[MAX_WAITERS]     = 1'b0;

  // Build the row of waiter cells
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    localparam logic [OCC_W-1:0] POS = OCC_W'(i);
    cell_ctl_t ctl;
    assign ctl.shift = do_shift;
    assign ctl.load  = do_load && (load_pos == POS);
    cstw_cell #(
      .ID_W (THREAD_ID_BITS),
      .TO_W (TIMEOUT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .nb_id_i      (c_id[i+1]),
      .nb_ticks_i   (c_ticks[i+1]),
      .nb_forever_i (c_forever[i+1]),
      .nb_exp_i     (c_exp[i+1]),
      .ld_id_i      (ld_id),
      .ld_ticks_i   (ld_ticks),
      .ld_forever_i (ld_forever),
      .ld_exp_i     (ld_exp),
      .id_o         (c_id[i]),
      .ticks_o      (c_ticks[i]),
      .forever_o    (c_forever[i]),
      .exp_o        (c_exp[i])
    );
  end

  // Count down the head waiter and flag expiry
  assign head_left = c_forever[0] ? c_ticks[0] :
                     ((c_ticks[0] != '0) ? c_ticks[0] - TIMEOUT_BITS'(1) : '0);
  assign head_exp  = !c_forever[0] && (head_left == '0);
  assign nexp_next = nexp_q + OCC_W'(head_exp);

  // Saturating count updates
  assign sum_inc   = $signed({count_q[COUNT_W-1], count_q}) + 17'sd1;
  assign count_inc = (sum_inc > COUNT_SAT) ? COUNT_MAX : sum_inc[COUNT_W-1:0];
  assign sum_exp   = $signed({count_q[COUNT_W-1], count_q})
                   + $signed({{(COUNT_W+1-OCC_W){1'b0}}, nexp_next});
  assign count_exp = (sum_exp > COUNT_SAT) ? COUNT_MAX : sum_exp[COUNT_W-1:0];

  assign accept  = start_i && (state_q == ST_IDLE);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_hit = cfg_wr && (paddr[ADDR_W-1] == REG_INIT_IDX);

  // Sequence the operations over the chain
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    step_d     = step_q;
    nexp_d     = nexp_q;
    count_d    = count_q;
    rv_d       = 1'b0;
    ev_d       = ev_q;
    tid_d      = tid_q;
    last_d     = last_q;
    do_shift   = 1'b0;
    do_load    = 1'b0;
    load_pos   = occ_q - ONE_STEP;
    ld_id      = c_id[0];
    ld_ticks   = c_ticks[0];
    ld_forever = c_forever[0];
    ld_exp     = c_exp[0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rv_d   = 1'b1;
          last_d = 1'b1;
          tid_d  = '0;
          case (opcode_i)
            OP_WAIT: begin
              tid_d = thread_id_i;
              if (count_q > 16'sd0) begin
                count_d = count_q - 16'sd1;
                ev_d    = EV_GRANTED;
              end else if (occ_q == OCC_FULL) begin
                ev_d = EV_FULL;
              end else begin
                do_load    = 1'b1;
                load_pos   = occ_q;
                ld_id      = thread_id_i;
                ld_ticks   = timeout_ticks_i;
                ld_forever = (timeout_ticks_i == '0);
                ld_exp     = 1'b0;
                occ_d      = occ_q + ONE_STEP;
                count_d    = count_q - 16'sd1;
                ev_d       = EV_BLOCKED;
              end
            end
            OP_SIGNAL: begin
              count_d = count_inc;
              if ((count_inc <= 16'sd0) && (occ_q != '0)) begin
                do_shift = 1'b1;
                occ_d    = occ_q - ONE_STEP;
                ev_d     = EV_SIGNALLED;
                tid_d    = c_id[0];
              end else begin
                ev_d = EV_NONE;
              end
            end
            OP_TICK: begin
              if (occ_q == '0) begin
                ev_d = EV_NONE;
              end else begin
                rv_d    = 1'b0;
                state_d = ST_MARK;
                step_d  = occ_q;
                nexp_d  = '0;
              end
            end
            default: begin
              ev_d = EV_REPORT;
            end
          endcase
        end
      end
      ST_MARK: begin
        // rotate once, writing back the counted-down head
        do_shift = 1'b1;
        do_load  = 1'b1;
        ld_ticks = head_left;
        ld_exp   = head_exp;
        nexp_d   = nexp_next;
        step_d   = step_q - ONE_STEP;
        if (step_q == ONE_STEP) begin
          count_d = count_exp;
          if (nexp_next == '0) begin
            rv_d    = 1'b1;
            ev_d    = EV_NONE;
            tid_d   = '0;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT;
            step_d  = occ_q;
          end
        end
      end
      ST_EMIT: begin
        // rotate once more, dropping and reporting expired waiters
        do_shift = 1'b1;
        if (c_exp[0]) begin
          occ_d  = occ_q - ONE_STEP;
          nexp_d = nexp_q - ONE_STEP;
          rv_d   = 1'b1;
          ev_d   = EV_TIMEDOUT;
          tid_d  = c_id[0];
          last_d = (nexp_q == ONE_STEP);
        end else begin
          do_load = 1'b1;
        end
        step_d = step_q - ONE_STEP;
        if (step_q == ONE_STEP) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_hit) begin
      count_d = $signed({1'b0, pwdata[INIT_W-1:0]});
    end
  end

  // Control and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      step_q  <= '0;
      nexp_q  <= '0;
      count_q <= '0;
      init_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      step_q  <= step_d;
      nexp_q  <= nexp_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      if (cfg_hit) begin
        init_q <= pwdata[INIT_W-1:0];
      end
    end
  end

  // Result word registers
  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    tid_q  <= tid_d;
    last_q <= last_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = rv_q;
  assign event_kind_o      = ev_q;
  assign released_thread_o = tid_q;
  assign count_value_o     = count_q;
  assign last_of_run_o     = last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_INIT_IDX) ?
                  {{(DATA_W-INIT_W){1'b0}}, init_q} : '0;

  // Queue never holds more than its slots
  `CSTW_NEVER(a_occ_bound, clk_i, rst_ni, occ_q > OCC_FULL)
  // Every marked expiry is emitted by the end of the second rotation
  `CSTW_ASSERT(a_emit_all, clk_i, rst_ni, (state_q == ST_EMIT && step_q == ONE_STEP) |=> (nexp_q == '0))
  // Non-tick commands answer in the next cycle
  `CSTW_ASSERT(a_quick_op, clk_i, rst_ni, (accept && opcode_i != OP_TICK) |=> (result_valid_o && last_of_run_o))

endmodule
